@@ rtl/totp_pkg.sv @@
// Shared constants, types and character decode helpers for the one-time password engine.
`default_nettype none
package totp_pkg;

  localparam int DEF_MAX_SECRET_CHARS = 128;
  localparam int HMAC_BLOCK_BYTES     = 64;

  localparam int TIME_W       = 40;
  localparam int CODE_W       = 30;
  localparam int LEN_W        = 4;
  localparam int CFG_W        = 12;
  localparam int CFG_IDX_W    = 2;
  localparam int CTR_W        = 64;
  localparam int DIGEST_W     = 160;
  localparam int DIGEST_BYTES = 20;
  localparam int CTR_BYTES    = 8;
  localparam int S_TDATA_W    = 88;
  localparam int M_TDATA_W    = 40;

  localparam logic [CFG_IDX_W-1:0] REG_CODE_DIGITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VERIFY_WINDOW = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_MODE     = 2'd3;

  localparam logic [7:0] IPAD        = 8'h36;
  localparam logic [7:0] OPAD        = 8'h5c;
  localparam logic [7:0] CH_EQUALS   = 8'h3D;
  localparam logic [7:0] TRUNC_MASK  = 8'h7F;
  localparam logic [7:0] PAD_MARKER  = 8'h80;

  localparam logic [11:0]      ALT_PERIOD   = 12'd30;
  localparam logic [LEN_W-1:0] ALT_DIGITS   = 4'd5;
  localparam logic [63:0]      ALT_CTR_MASK = 64'h0000_0000_FFFF_FFFF;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  typedef struct packed {
    logic init;
    logic push;
    logic finish;
  } sha_ctl_t;

  // {valid, value}; alphabet A-Z then 2-7, case folded
  function automatic logic [5:0] b32_decode(input logic [7:0] ch);
    logic [7:0] u;
    u = (ch >= 8'h61 && ch <= 8'h7A) ? ch - 8'd32 : ch;
    if (u >= 8'h41 && u <= 8'h5A) return {1'b1, 5'(u - 8'h41)};
    else if (u >= 8'h32 && u <= 8'h37) return {1'b1, 5'(u - 8'h32 + 8'd26)};
    else return 6'd0;
  endfunction

  // {valid, value}; url-safe characters map onto the standard ones
  function automatic logic [6:0] b64_decode(input logic [7:0] ch);
    if (ch >= 8'h41 && ch <= 8'h5A) return {1'b1, 6'(ch - 8'h41)};
    else if (ch >= 8'h61 && ch <= 8'h7A) return {1'b1, 6'(ch - 8'h61 + 8'd26)};
    else if (ch >= 8'h30 && ch <= 8'h39) return {1'b1, 6'(ch - 8'h30 + 8'd52)};
    else if (ch == 8'h2B || ch == 8'h2D) return {1'b1, 6'd62};
    else if (ch == 8'h2F || ch == 8'h5F) return {1'b1, 6'd63};
    else return 7'd0;
  endfunction

  function automatic logic [CODE_W-1:0] pow10(input logic [LEN_W-1:0] d);
    case (d)
      4'd2:    return 30'd100;
      4'd3:    return 30'd1000;
      4'd4:    return 30'd10000;
      4'd5:    return 30'd100000;
      4'd6:    return 30'd1000000;
      4'd7:    return 30'd10000000;
      4'd8:    return 30'd100000000;
      4'd9:    return 30'd1000000000;
      default: return 30'd10;
    endcase
  endfunction

endpackage
`default_nettype wire

@@ rtl/totp_div.sv @@
// Restoring divider, one quotient bit per cycle; gives quotient and remainder.
`default_nettype none
module totp_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [totp_pkg::TIME_W-1:0]   dividend,
  input  logic [totp_pkg::CODE_W-1:0]   divisor,
  output logic                          busy,
  output logic [totp_pkg::TIME_W-1:0]   quot,
  output logic [totp_pkg::CODE_W-1:0]   rem
);
  import totp_pkg::*;

  localparam int CntW = $clog2(TIME_W + 1);

  logic [CODE_W-1:0] d;
  logic [CntW-1:0]   cnt;
  logic [CODE_W:0]   r_sh;
  logic [CODE_W:0]   r_sub;
  logic              ge;

  assign r_sh  = {rem, quot[TIME_W-1]};
  assign r_sub = r_sh - {1'b0, d};
  assign ge    = (r_sh >= {1'b0, d});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      quot <= dividend;
      rem  <= '0;
      d    <= divisor;
      cnt  <= '0;
      busy <= 1'b1;
    end else if (busy) begin
      quot <= {quot[TIME_W-2:0], ge};
      rem  <= ge ? r_sub[CODE_W-1:0] : r_sh[CODE_W-1:0];
      cnt  <= cnt + 1'b1;
      if (cnt == CntW'(TIME_W - 1)) busy <= 1'b0;
    end
  end
endmodule
`default_nettype wire

@@ rtl/totp_sha1.sv @@
// SHA-1 unit: byte-wide absorb, built-in padding, one round per cycle.
`default_nettype none
module totp_sha1 (
  input  logic                            clk,
  input  logic                            rst,
  input  totp_pkg::sha_ctl_t              ctl,
  input  logic [7:0]                      byte_in,
  output logic                            ready,
  output logic                            done,
  output logic [totp_pkg::DIGEST_W-1:0]   digest
);
  import totp_pkg::*;

  typedef enum logic [3:0] {
    SH_IDLE  = 4'b0001,
    SH_PAD   = 4'b0010,
    SH_ROUND = 4'b0100,
    SH_ADD   = 4'b1000
  } sh_state_t;

  sh_state_t   state;
  logic [31:0] h [5];
  logic [31:0] a, b, c, d, e;
  logic [511:0] blk;  // 16-word schedule window, W[t] on top
  logic [5:0]  fill;
  logic [15:0] len;
  logic [6:0]  rnd;
  logic        padding, marker, lenph, final_blk;

  logic [63:0] lenbits;
  logic [2:0]  lsel;
  logic        len_now;
  logic [7:0]  pad_byte;
  logic [31:0] wx, wnew, f, k, tmp;

  assign ready  = (state == SH_IDLE);
  assign digest = {h[0], h[1], h[2], h[3], h[4]};

  assign lenbits  = {45'd0, len, 3'b000};
  assign lsel     = 3'd7 - fill[2:0];
  assign len_now  = marker && (lenph || fill == 6'd56);
  assign pad_byte = !marker ? PAD_MARKER : (len_now ? lenbits[{lsel, 3'b000} +: 8] : 8'h00);

  assign wx   = blk[95:64] ^ blk[255:224] ^ blk[447:416] ^ blk[511:480];
  assign wnew = {wx[30:0], wx[31]};

  always_comb begin
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
    tmp = {a[26:0], a[31:27]} + f + e + k + blk[511:480];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SH_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        SH_IDLE: begin
          if (ctl.init) begin
            h[0] <= IV0; h[1] <= IV1; h[2] <= IV2; h[3] <= IV3; h[4] <= IV4;
            fill      <= '0;
            len       <= '0;
            padding   <= 1'b0;
            marker    <= 1'b0;
            lenph     <= 1'b0;
            final_blk <= 1'b0;
          end else if (ctl.push) begin
            blk  <= {blk[503:0], byte_in};
            fill <= fill + 1'b1;
            len  <= len + 1'b1;
            if (fill == 6'd63) begin
              state <= SH_ROUND;
              rnd   <= '0;
              a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
            end
          end else if (ctl.finish) begin
            padding <= 1'b1;
            marker  <= 1'b0;
            lenph   <= 1'b0;
            state   <= SH_PAD;
          end
        end
        SH_PAD: begin
          blk    <= {blk[503:0], pad_byte};
          fill   <= fill + 1'b1;
          marker <= 1'b1;
          if (len_now) lenph <= 1'b1;
          if (len_now && fill == 6'd63) final_blk <= 1'b1;
          if (fill == 6'd63) begin
            state <= SH_ROUND;
            rnd   <= '0;
            a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
          end
        end
        SH_ROUND: begin
          e   <= d;
          d   <= c;
          c   <= {b[1:0], b[31:2]};
          b   <= a;
          a   <= tmp;
          blk <= {blk[479:0], wnew};
          rnd <= rnd + 1'b1;
          if (rnd == 7'd79) state <= SH_ADD;
        end
        SH_ADD: begin
          h[0] <= h[0] + a; h[1] <= h[1] + b; h[2] <= h[2] + c;
          h[3] <= h[3] + d; h[4] <= h[4] + e;
          if (final_blk) begin
            done      <= 1'b1;
            padding   <= 1'b0;
            final_blk <= 1'b0;
            state     <= SH_IDLE;
          end else if (padding) begin
            state <= SH_PAD;
          end else begin
            state <= SH_IDLE;
          end
        end
        default: state <= SH_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/totp_code_engine.sv @@
// Time-based one-time password engine (HMAC-SHA1). Secret characters stream in one beat per
// cycle while the engine is idle and go into a secret memory; beats past MAX_SECRET_CHARS are
// dropped and flagged. The beat with tlast also carries the timestamp and an optional code to
// verify, and yields one result beat. On that beat the secret is swept out of its memory (one
// character per cycle, twice when the base64 pass gives no bytes) into a key memory, while a
// shared restoring divider forms counter = time / period. Keys over 64 bytes are hashed first
// and the 20-byte digest is written back into the key memory. Each HMAC costs four SHA-1
// blocks: byte absorb and padding (one byte per cycle while the SHA-1 unit is ready), the
// SHA-1 rounds and a divide for the mod 10^digits step; a verify adds up to 2*verify_window+1
// more HMACs, stopping at the first match.
// Config writes are accepted at any time but must only be issued while the engine is idle.
`default_nettype none
module totp_code_engine #(
  parameter int MAX_SECRET_CHARS = totp_pkg::DEF_MAX_SECRET_CHARS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // secret_char[7:0], time_seconds[47:8], verify_request[48], given_code[78:49],
  // given_length[82:79], zero fill above
  input  logic [totp_pkg::S_TDATA_W-1:0]      s_tdata,
  input  logic                                s_tlast,   // last_char
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // otp_value[29:0], otp_length[33:30], key_empty[34], code_match[35],
  // secret_overflow[36], zero fill above
  output logic [totp_pkg::M_TDATA_W-1:0]      m_tdata,
  input  logic                                cfg_we,
  input  logic [totp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [totp_pkg::CFG_W-1:0]          cfg_wdata
);
  import totp_pkg::*;

  localparam int SecAw       = $clog2(MAX_SECRET_CHARS);
  localparam int CntW        = $clog2(MAX_SECRET_CHARS + 1);
  localparam int KeyCap      = (MAX_SECRET_CHARS * 3) / 4 + 1;
  localparam int KeyAw       = $clog2(KeyCap);
  localparam int KlenW       = $clog2(KeyCap + 1);
  localparam int InnerBytes  = HMAC_BLOCK_BYTES + CTR_BYTES;
  localparam int OuterBytes  = HMAC_BLOCK_BYTES + DIGEST_BYTES;
  localparam int IdxMin      = $clog2(OuterBytes + 1);
  localparam int IdxW        = (CntW > IdxMin) ? CntW : IdxMin;

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b0000_0000_0001,
    ST_DPRIME = 12'b0000_0000_0010,
    ST_DEC    = 12'b0000_0000_0100,
    ST_DIVT   = 12'b0000_0000_1000,
    ST_HINIT  = 12'b0000_0001_0000,
    ST_FEED   = 12'b0000_0010_0000,
    ST_FIN    = 12'b0000_0100_0000,
    ST_WAIT   = 12'b0000_1000_0000,
    ST_KWB    = 12'b0001_0000_0000,
    ST_TRUNC  = 12'b0010_0000_0000,
    ST_MOD    = 12'b0100_0000_0000,
    ST_DONE   = 12'b1000_0000_0000
  } state_t;

  typedef enum logic [1:0] {
    HS_KEY   = 2'd0,
    HS_INNER = 2'd1,
    HS_OUTER = 2'd2
  } hsel_t;

  // config registers
  logic [LEN_W-1:0] code_digits;
  logic [11:0]      period_seconds;
  logic [3:0]       verify_window;
  logic             code_mode;

  state_t state;
  hsel_t  hsel;

  // memories
  logic [7:0] sec_mem [MAX_SECRET_CHARS];
  logic [7:0] key_mem [KeyCap];
  logic [7:0] sec_rd, key_rd;
  logic       sec_we, key_we;
  logic [KeyAw-1:0] key_waddr;
  logic [7:0]       key_wdata;

  logic [CntW-1:0]  char_count;
  logic             overflow_seen;
  logic [IdxW-1:0]  idx, idx_next;
  logic [KlenW-1:0] klen;
  logic             sixbit_dec;
  logic [15:0]      acc;
  logic [3:0]       have;

  logic              vreq;
  logic [CODE_W-1:0] gval;
  logic [LEN_W-1:0]  glen;
  logic [CTR_W-1:0]  ctr, hctr;
  logic [DIGEST_W-1:0] inner_dig;
  logic [CODE_W-1:0] otp;
  logic              match, verifying;
  logic [4:0]        j;

  // per-item helpers
  logic              in_acc;
  logic [LEN_W-1:0]  digits_eff;
  logic [CODE_W-1:0] modulus;
  logic [11:0]       per_eff;

  // decode datapath
  logic [5:0]  b32v;
  logic [6:0]  b64v;
  logic        dv, dec_end, kfull;
  logic [15:0] acc_new;
  logic [3:0]  have_new;
  logic [3:0]  kshift;
  logic [15:0] acc_sh;

  // hash feed
  sha_ctl_t          sha_ctl;
  logic              sha_ready, sha_done;
  logic [DIGEST_W-1:0] sha_digest;
  logic [7:0]        feed_byte, key_b, ctr_byte, inner_byte;
  logic [IdxW-1:0]   feed_len;
  logic [4:0]        isel;
  logic [DIGEST_W-1:0] inner_sh, wb_sh, trunc_sh;
  logic [30:0]       bin;

  // divider
  logic              div_start, div_busy;
  logic [TIME_W-1:0] div_dividend, div_quot;
  logic [CODE_W-1:0] div_divisor, div_rem;

  assign in_acc   = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);

  assign digits_eff = code_mode ? ALT_DIGITS :
                      (code_digits == 4'd0) ? 4'd1 :
                      (code_digits > 4'd9) ? 4'd9 : code_digits;
  assign modulus    = pow10(digits_eff);
  assign per_eff    = code_mode ? ALT_PERIOD :
                      (period_seconds == 12'd0) ? 12'd1 : period_seconds;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      code_digits    <= 4'd6;
      period_seconds <= 12'd30;
      verify_window  <= 4'd1;
      code_mode      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CODE_DIGITS:   code_digits    <= cfg_wdata[LEN_W-1:0];
        REG_PERIOD:        period_seconds <= cfg_wdata;
        REG_VERIFY_WINDOW: verify_window  <= cfg_wdata[3:0];
        REG_CODE_MODE:     code_mode      <= cfg_wdata[0];
      endcase
    end
  end

  // ---------------- secret and key memories ----------------
  assign sec_we = in_acc && (char_count < CntW'(MAX_SECRET_CHARS));

  always_ff @(posedge clk) begin
    if (sec_we) sec_mem[char_count[SecAw-1:0]] <= s_tdata[7:0];
    sec_rd <= sec_mem[idx_next[SecAw-1:0]];
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_waddr] <= key_wdata;
    key_rd <= key_mem[idx_next[KeyAw-1:0]];
  end

  // ---------------- secret decode ----------------
  assign b32v    = b32_decode(sec_rd);
  assign b64v    = b64_decode(sec_rd);
  assign dv      = sixbit_dec ? b64v[6] : b32v[5];
  assign dec_end = (idx == IdxW'(char_count)) || (sixbit_dec && sec_rd == CH_EQUALS);
  assign acc_new  = sixbit_dec ? {acc[9:0], b64v[5:0]} : {acc[10:0], b32v[4:0]};
  assign have_new = have + (sixbit_dec ? 4'd6 : 4'd5);
  assign kshift   = have_new - 4'd8;
  assign acc_sh   = acc_new >> kshift;
  assign kfull    = (klen == KlenW'(KeyCap));

  // digest byte for key write-back
  assign wb_sh = sha_digest << {idx[4:0], 3'b000};

  always_comb begin
    key_we    = 1'b0;
    key_waddr = klen[KeyAw-1:0];
    key_wdata = acc_sh[7:0];
    if (state == ST_DEC) begin
      key_we = !dec_end && dv && (have_new >= 4'd8) && !kfull;
    end else if (state == ST_KWB) begin
      key_we    = 1'b1;
      key_waddr = idx[KeyAw-1:0];
      key_wdata = wb_sh[DIGEST_W-1 -: 8];
    end
  end

  // ---------------- hash byte source ----------------
  assign key_b      = (IdxW'(klen) > idx) ? key_rd : 8'h00;
  assign ctr_byte   = hctr[{3'd7 - idx[2:0], 3'b000} +: 8];
  assign isel       = 5'(idx - IdxW'(HMAC_BLOCK_BYTES));
  assign inner_sh   = inner_dig << {isel, 3'b000};
  assign inner_byte = inner_sh[DIGEST_W-1 -: 8];

  always_comb begin
    case (hsel)
      HS_INNER: begin
        feed_byte = (idx < IdxW'(HMAC_BLOCK_BYTES)) ? (key_b ^ IPAD) : ctr_byte;
        feed_len  = IdxW'(InnerBytes);
      end
      HS_OUTER: begin
        feed_byte = (idx < IdxW'(HMAC_BLOCK_BYTES)) ? (key_b ^ OPAD) : inner_byte;
        feed_len  = IdxW'(OuterBytes);
      end
      default: begin
        feed_byte = key_rd;
        feed_len  = IdxW'(klen);
      end
    endcase
  end

  assign sha_ctl.init   = (state == ST_HINIT);
  assign sha_ctl.push   = (state == ST_FEED) && sha_ready;
  assign sha_ctl.finish = (state == ST_FIN) && sha_ready;

  totp_sha1 u_sha (
    .clk     (clk),
    .rst     (rst),
    .ctl     (sha_ctl),
    .byte_in (feed_byte),
    .ready   (sha_ready),
    .done    (sha_done),
    .digest  (sha_digest)
  );

  // dynamic truncation: offset from the low nibble of the last digest byte
  assign trunc_sh = sha_digest << {sha_digest[3:0], 3'b000};
  assign bin      = {trunc_sh[DIGEST_W-2 -: 7] & TRUNC_MASK[6:0], trunc_sh[DIGEST_W-9 -: 24]};

  // ---------------- divider ----------------
  assign div_start    = in_acc && s_tlast || (state == ST_TRUNC);
  assign div_dividend = (state == ST_TRUNC) ? TIME_W'(bin) : s_tdata[47:8];
  assign div_divisor  = (state == ST_TRUNC) ? modulus : CODE_W'(per_eff);

  totp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // ---------------- sequencer ----------------
  always_comb begin
    unique case (state)
      ST_DEC:  idx_next = dec_end ? '0 : IdxW'(idx + 1'b1);
      ST_FEED: idx_next = sha_ready ? IdxW'(idx + 1'b1) : idx;
      ST_KWB:  idx_next = IdxW'(idx + 1'b1);
      default: idx_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      char_count    <= '0;
      overflow_seen <= 1'b0;
      m_tvalid      <= 1'b0;
      idx           <= '0;
    end else begin
      idx <= idx_next;
      // result register: load from the done state when free, else drain on accept
      if (state == ST_DONE && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (sec_we) char_count <= CntW'(char_count + 1'b1);
            else        overflow_seen <= 1'b1;
            if (s_tlast) begin
              vreq       <= s_tdata[48];
              gval       <= s_tdata[78:49];
              glen       <= s_tdata[82:79];
              sixbit_dec <= code_mode;
              klen       <= '0;
              acc        <= '0;
              have       <= '0;
              state      <= ST_DPRIME;
            end
          end
        end
        ST_DPRIME: state <= ST_DEC;
        ST_DEC: begin
          if (dec_end) begin
            if (sixbit_dec && klen == '0) begin
              // nothing came out of base64: read the secret again as base32
              sixbit_dec <= 1'b0;
              acc        <= '0;
              have       <= '0;
              state      <= ST_DPRIME;
            end else begin
              state <= ST_DIVT;
            end
          end else if (dv) begin
            acc  <= acc_new;
            have <= (have_new >= 4'd8) ? kshift : have_new;
            if (have_new >= 4'd8 && !kfull) klen <= KlenW'(klen + 1'b1);
          end
        end
        ST_DIVT: begin
          if (!div_busy) begin
            ctr       <= code_mode ? (CTR_W'(div_quot) & ALT_CTR_MASK) : CTR_W'(div_quot);
            hctr      <= code_mode ? (CTR_W'(div_quot) & ALT_CTR_MASK) : CTR_W'(div_quot);
            verifying <= 1'b0;
            match     <= 1'b0;
            if (klen == '0) begin
              otp   <= '0;
              match <= vreq && !code_mode && (glen == '0);
              state <= ST_DONE;
            end else if (IdxW'(klen) > IdxW'(HMAC_BLOCK_BYTES)) begin
              hsel  <= HS_KEY;
              state <= ST_HINIT;
            end else begin
              hsel  <= HS_INNER;
              state <= ST_HINIT;
            end
          end
        end
        ST_HINIT: state <= ST_FEED;
        ST_FEED: begin
          if (sha_ready && idx == IdxW'(feed_len - 1'b1)) state <= ST_FIN;
        end
        ST_FIN: begin
          if (sha_ready) state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (sha_done) begin
            case (hsel)
              HS_KEY:   state <= ST_KWB;
              HS_INNER: begin
                inner_dig <= sha_digest;
                hsel      <= HS_OUTER;
                state     <= ST_HINIT;
              end
              default:  state <= ST_TRUNC;
            endcase
          end
        end
        ST_KWB: begin
          // long key replaced by its digest
          if (idx == IdxW'(DIGEST_BYTES - 1)) begin
            klen  <= KlenW'(DIGEST_BYTES);
            hsel  <= HS_INNER;
            state <= ST_HINIT;
          end
        end
        ST_TRUNC: state <= ST_MOD;
        ST_MOD: begin
          if (!div_busy) begin
            if (!verifying) begin
              otp <= div_rem;
              if (vreq && !code_mode && glen == digits_eff) begin
                verifying <= 1'b1;
                j         <= '0;
                hctr      <= ctr - CTR_W'(verify_window);
                hsel      <= HS_INNER;
                state     <= ST_HINIT;
              end else begin
                state <= ST_DONE;
              end
            end else if (div_rem == gval) begin
              match <= 1'b1;
              state <= ST_DONE;
            end else if (j == {verify_window, 1'b0}) begin
              state <= ST_DONE;
            end else begin
              j     <= j + 1'b1;
              hctr  <= hctr + 1'b1;
              hsel  <= HS_INNER;
              state <= ST_HINIT;
            end
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata       <= {3'b000, overflow_seen, match, (klen == '0),
                              (klen == '0) ? 4'd0 : digits_eff, otp};
            char_count    <= '0;
            overflow_seen <= 1'b0;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
